// ===== design/bitmap_set_clear_count_find_first_unit_macros.svh =====
// Assertion shorthands for the bitmap unit; clock and reset names are the house ones.
`ifndef BITMAP_SET_CLEAR_COUNT_FIND_FIRST_UNIT_MACROS_SVH
`define BITMAP_SET_CLEAR_COUNT_FIND_FIRST_UNIT_MACROS_SVH

// Same-cycle implication.
`define BMSCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BMSCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bmscf_pkg.sv =====
package bmscf_pkg;

    localparam int WORD_BITS = 64;
    localparam int IDX_SHIFT = 6;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int MAX_WORDS = 16;
    localparam int WA_W      = 4;
    localparam int FFS_W     = 16;
    localparam int POS_W     = 4;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    typedef struct packed {
        logic            rd_en;
        logic [WA_W-1:0] rd_addr;
        logic            wr_en;
        logic [WA_W-1:0] wr_addr;
    } t_mem_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_ffs;

endpackage

// ===== design/bmscf_req_if.sv =====
interface bmscf_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [bmscf_pkg::IDX_W-1:0]   bit_index;

    modport source (output valid, output opcode, output bit_index, input ready);
    modport sink (input valid, input opcode, input bit_index, output ready);
endinterface

// ===== design/bmscf_res_if.sv =====
interface bmscf_res_if;
    logic                          valid;
    logic                          ready;
    logic                          bit_value;
    logic [bmscf_pkg::CNT_W-1:0]   set_count;
    logic                          any_set;
    logic [bmscf_pkg::IDX_W-1:0]   first_set_index;

    modport source (output valid, output bit_value, output set_count, output any_set,
                    output first_set_index, input ready);
    modport sink (input valid, input bit_value, input set_count, input any_set,
                  input first_set_index, output ready);
endinterface

// ===== design/bmscf_ffs.sv =====
module bmscf_ffs (
    input  logic [bmscf_pkg::FFS_W-1:0] i_bits,
    output bmscf_pkg::t_ffs             o_res
);

    // Lowest set bit wins: scan from the top down.
    always_comb begin
        o_res.found = |i_bits;
        o_res.pos   = '0;
        for (int i = bmscf_pkg::FFS_W - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_res.pos = bmscf_pkg::POS_W'(i);
            end
        end
    end

endmodule

// ===== design/bmscf_store.sv =====
module bmscf_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmscf_pkg::t_mem_req                 i_mem_req,
    input  logic [bmscf_pkg::WORD_BITS-1:0]     i_wr_data,
    output logic [bmscf_pkg::WORD_BITS-1:0]     o_rd_data
);

    logic [bmscf_pkg::WORD_BITS-1:0] r_mem [DEPTH];
    logic [bmscf_pkg::WORD_BITS-1:0] r_rd_data;
    logic [DEPTH-1:0]                r_vld;
    logic                            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr_en) begin
            r_mem[i_mem_req.wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (i_mem_req.rd_en) begin
            r_rd_data <= r_mem[i_mem_req.rd_addr[AW-1:0]];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_mem_req.wr_en) begin
                r_vld[i_mem_req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_mem_req.rd_en) begin
                r_rd_vld <= r_vld[i_mem_req.rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== design/bitmap_set_clear_count_find_first_unit.sv =====
// Channel   Dir  Fields                                            Taken when
// i_req     in   opcode[1:0], bit_index[9:0]                       valid && ready
// o_res     out  bit_value, set_count[10:0], any_set,              valid && ready
//                first_set_index[9:0]
// A request runs through word read, modify/write, summary encode plus word read,
// byte encode and bit encode; the one read port of the word memory and the one
// shared first-set encoder make them run one after another. A new request is
// taken only in idle, while the previous result may still wait; the last step
// holds until the result register is free. Reset is synchronous and clears the
// word valid bits, the count and the nonzero-word summary at once; no clearing pass.
module bitmap_set_clear_count_find_first_unit #(
    parameter int BITS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmscf_req_if.sink    i_req,
    bmscf_res_if.source  o_res
);

`include "bitmap_set_clear_count_find_first_unit_macros.svh"

    localparam int NUM_WORDS = (BITS + bmscf_pkg::WORD_BITS - 1) / bmscf_pkg::WORD_BITS;
    localparam int DEPTH     = (NUM_WORDS < bmscf_pkg::MAX_WORDS) ? NUM_WORDS
                                                                : bmscf_pkg::MAX_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [bmscf_pkg::CNT_W-1:0] CNT_MAX =
        bmscf_pkg::CNT_W'(DEPTH * bmscf_pkg::WORD_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_FIND,
        S_BYTE,
        S_BIT
    } t_state;

    t_state                              r_state;
    logic [1:0]                          r_op;
    logic [bmscf_pkg::IDX_W-1:0]         r_idx;
    logic                                r_in_range;
    logic [bmscf_pkg::CNT_W-1:0]         r_count;
    logic [DEPTH-1:0]                    r_nz;
    logic                                r_value;
    logic                                r_any;
    logic [bmscf_pkg::WA_W-1:0]          r_fw;
    logic [2:0]                          r_fbyte;
    logic [7:0]                          r_byte;
    logic                                r_out_vld;
    logic                                r_o_value;
    logic [bmscf_pkg::CNT_W-1:0]         r_o_count;
    logic                                r_o_any;
    logic [bmscf_pkg::IDX_W-1:0]         r_o_first;

    bmscf_pkg::t_mem_req                 mem_req;
    logic [bmscf_pkg::WORD_BITS-1:0]     rd_word;
    logic [bmscf_pkg::WORD_BITS-1:0]     mod_word;
    logic [bmscf_pkg::WORD_BITS-1:0]     bit_mask;
    logic [bmscf_pkg::WA_W-1:0]          req_word;
    logic [bmscf_pkg::WA_W-1:0]          cur_word;
    logic [5:0]                          cur_bit;
    logic                                was_set;
    logic [7:0]                          byte_nz;
    logic [bmscf_pkg::FFS_W-1:0]         ffs_in;
    bmscf_pkg::t_ffs                     ffs_res;
    logic                                accept;
    logic                                out_free;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_vld || o_res.ready;
    assign req_word = i_req.bit_index[bmscf_pkg::IDX_W-1:bmscf_pkg::IDX_SHIFT];
    assign cur_word = r_idx[bmscf_pkg::IDX_W-1:bmscf_pkg::IDX_SHIFT];
    assign cur_bit  = r_idx[bmscf_pkg::IDX_SHIFT-1:0];
    assign bit_mask = bmscf_pkg::WORD_BITS'(1) << cur_bit;
    assign was_set  = rd_word[cur_bit];

    always_comb begin
        case (r_op)
            bmscf_pkg::OP_SET:   mod_word = rd_word | bit_mask;
            bmscf_pkg::OP_CLEAR: mod_word = rd_word & ~bit_mask;
            default:             mod_word = rd_word;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            byte_nz[k] = |rd_word[8*k +: 8];
        end
    end

    // Share one encoder: word summary, then byte flags, then bits of one byte.
    always_comb begin
        case (r_state)
            S_FIND:  ffs_in = bmscf_pkg::FFS_W'(r_nz);
            S_BYTE:  ffs_in = bmscf_pkg::FFS_W'(byte_nz);
            S_BIT:   ffs_in = bmscf_pkg::FFS_W'(r_byte);
            default: ffs_in = '0;
        endcase
    end

    always_comb begin
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = req_word;
        mem_req.wr_en   = (r_state == S_MOD) && r_in_range;
        mem_req.wr_addr = cur_word;
        if (r_state == S_IDLE) begin
            mem_req.rd_en = accept;
        end else if (r_state == S_FIND) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ffs_res.pos;
        end
    end

    bmscf_ffs u_ffs (
        .i_bits (ffs_in),
        .o_res  (ffs_res)
    );

    bmscf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mem_req (mem_req),
        .i_wr_data (mod_word),
        .o_rd_data (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_nz      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // Load a new result first; otherwise drop the one just taken.
            if (r_state == S_BIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op       <= i_req.opcode;
                        r_idx      <= i_req.bit_index;
                        r_in_range <= (32'(i_req.bit_index) < BITS);
                        r_state    <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_value <= r_in_range && mod_word[cur_bit];
                    if (r_in_range) begin
                        r_nz[cur_word[AW-1:0]] <= |mod_word;
                        if (r_op == bmscf_pkg::OP_SET && !was_set) begin
                            r_count <= r_count + 1'b1;
                        end else if (r_op == bmscf_pkg::OP_CLEAR && was_set) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    r_any   <= ffs_res.found;
                    r_fw    <= ffs_res.pos;
                    r_state <= S_BYTE;
                end
                S_BYTE: begin
                    r_fbyte <= ffs_res.pos[2:0];
                    r_byte  <= rd_word[8*ffs_res.pos[2:0] +: 8];
                    r_state <= S_BIT;
                end
                S_BIT: begin
                    // Hold until the result register can take the new result.
                    if (out_free) begin
                        r_o_value <= r_value;
                        r_o_count <= r_count;
                        r_o_any   <= r_any;
                        r_o_first <= r_any ? {r_fw, r_fbyte, ffs_res.pos[2:0]} : '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_out_vld;
    assign o_res.bit_value       = r_o_value;
    assign o_res.set_count       = r_o_count;
    assign o_res.any_set         = r_o_any;
    assign o_res.first_set_index = r_o_first;

    `BMSCF_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_MAX, "set count above store size")
    `BMSCF_ASSERT_NOW(a_sum_count, r_state == S_FIND,
                      ffs_res.found == (r_count != '0), "summary and count disagree")
    `BMSCF_ASSERT_NOW(a_word_nz, r_state == S_BYTE && r_any, rd_word != '0,
                      "first nonzero word reads zero")
    `BMSCF_ASSERT_NEXT(a_set_sticks,
                       r_state == S_MOD && r_in_range && r_op == bmscf_pkg::OP_SET,
                       r_value && r_count != '0, "set bit not reported")

endmodule
